>>> rtl/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

    localparam int CFG_WIDTH = 7;
    localparam logic [CFG_WIDTH-1:0] WINDOW_LENGTH_RESET = 7'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COMPARE,
        ST_UPDATE,
        ST_EMIT
    } swm_state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic compare;
        logic update;
        logic emit;
    } swm_cmd_t;

    typedef struct packed {
        logic has_result;
        logic out_free;
    } swm_status_t;

endpackage

>>> rtl/sliding_window_median.sv
// a word that leaves the window full goes through read, compare, update and emit
// before its result word is on m_valid; one word is in work at a time
// a result waits in the output register while the next word is taken
// reset: synchronous active-low aresetn clears the window, length back to 3
// sample stores are not cleared; no clearing pass after reset
`timescale 1ns / 1ps

module sliding_window_median import swm_pkg::*; #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [CFG_WIDTH-1:0]           cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    input  logic                           s_starts_sequence,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH:0]   m_median_doubled
);

    swm_cmd_t    cmd;
    swm_status_t status;

    swm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    swm_datapath #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_sample          (s_sample),
        .s_starts_sequence (s_starts_sequence),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_median_doubled  (m_median_doubled),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

>>> rtl/swm_ctrl.sv
`timescale 1ns / 1ps

module swm_ctrl import swm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  swm_status_t status,
    output swm_cmd_t    cmd
);

    swm_state_t state_reg;
    swm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_COMPARE;
            end
            ST_COMPARE: begin
                cmd.compare = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                priority if (!status.has_result) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/swm_datapath.sv
`timescale 1ns / 1ps

module swm_datapath import swm_pkg::*; #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [CFG_WIDTH-1:0]           cfg_wr_data,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    input  logic                           s_starts_sequence,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH:0]   m_median_doubled,
    input  swm_cmd_t                       cmd,
    output swm_status_t                    status
);

    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);

    logic [CFG_WIDTH-1:0]           wl_reg;
    logic [CW-1:0]                  len;
    logic [CW-1:0]                  fill_reg;
    logic [CW-1:0]                  fill_next;
    logic [IW-1:0]                  ptr_reg;
    logic [IW-1:0]                  ptr_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] old_reg;
    logic                           full_reg;
    logic                           res_reg;
    logic [WINDOW_MAX-1:0]          ge_reg;
    logic [WINDOW_MAX-1:0]          le_reg;
    logic signed [SAMPLE_WIDTH-1:0] sorted_reg [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] sorted_next [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] arrival_mem [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] bval [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]          ble;
    logic [CW-1:0]                  blen;
    logic [IW-1:0]                  wr_addr;
    logic [IW-1:0]                  lo_idx;
    logic [IW-1:0]                  hi_idx;
    logic signed [SAMPLE_WIDTH:0]   sum;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic signed [SAMPLE_WIDTH:0]   m_data_reg;

    // window length clamped to 1 .. WINDOW_MAX
    always_comb begin
        priority if (wl_reg == '0) begin
            len = CW'(1);
        end else if (32'(wl_reg) > WINDOW_MAX) begin
            len = CW'(WINDOW_MAX);
        end else begin
            len = CW'(wl_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg <= WINDOW_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            wl_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        priority if (cfg_wr_en) begin
            fill_next = '0;
            ptr_next  = '0;
        end else if (cmd.load && s_starts_sequence) begin
            fill_next = '0;
            ptr_next  = '0;
        end else if (cmd.update) begin
            if (full_reg) begin
                fill_next = len;
                ptr_next  = (CW'(ptr_reg) + CW'(1) == len) ? '0 : ptr_reg + IW'(1);
            end else begin
                fill_next = fill_reg + CW'(1);
                ptr_next  = '0;
            end
        end else begin
            fill_next = fill_reg;
            ptr_next  = ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ptr_reg  <= '0;
            full_reg <= 1'b0;
            res_reg  <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            if (cmd.read) begin
                full_reg <= (fill_reg >= len);
            end
            if (cmd.update) begin
                res_reg <= full_reg || (fill_reg + CW'(1) >= len);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_sample;
        end
    end

    // arrival ring
    assign wr_addr = full_reg ? ptr_reg : fill_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            arrival_mem[wr_addr] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            old_reg <= arrival_mem[ptr_reg];
        end
    end

    // sorted cell chain
    assign blen = full_reg ? len - CW'(1) : fill_reg;

    for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
        logic shifted;
        logic le_b;

        always_ff @(posedge aclk) begin
            if (cmd.compare) begin
                ge_reg[j] <= (sorted_reg[j] >= old_reg);
                le_reg[j] <= (sorted_reg[j] <= sample_reg);
            end
        end

        if (j < WINDOW_MAX - 1) begin : g_shift
            assign shifted = full_reg && ge_reg[j];
            assign bval[j] = shifted ? sorted_reg[j+1] : sorted_reg[j];
            assign le_b    = shifted ? le_reg[j+1] : le_reg[j];
        end else begin : g_last
            assign shifted = 1'b0;
            assign bval[j] = sorted_reg[j];
            assign le_b    = le_reg[j] && !shifted;
        end

        assign ble[j] = (CW'(j) < blen) && le_b;

        if (j == 0) begin : g_head
            assign sorted_next[j] = ble[j] ? bval[j] : sample_reg;
        end else begin : g_body
            assign sorted_next[j] = ble[j]   ? bval[j]    :
                                    ble[j-1] ? sample_reg : bval[j-1];
        end

        always_ff @(posedge aclk) begin
            if (cmd.update) begin
                sorted_reg[j] <= sorted_next[j];
            end
        end
    end

    // two middle entries
    assign lo_idx = IW'((len - CW'(1)) >> 1);
    assign hi_idx = IW'(len >> 1);
    assign sum    = (SAMPLE_WIDTH+1)'(sorted_reg[lo_idx]) + (SAMPLE_WIDTH+1)'(sorted_reg[hi_idx]);

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= sum;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_median_doubled  = m_data_reg;
    assign status.has_result = res_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule

>>> rtl/swm_checker.sv
`timescale 1ns / 1ps

module swm_checker import swm_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [SAMPLE_WIDTH:0]   m_median_doubled
);

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_median_doubled))
        else $error("stalled result word changed");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in work");

    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result word appeared while input side was idle");

endmodule

bind sliding_window_median swm_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_swm_checker (.*);
